### rtl/core/bitmap_sector_allocator_macros.svh
// assertion macros used by the allocator rtl
`ifndef BITMAP_SECTOR_ALLOCATOR_MACROS_SVH
`define BITMAP_SECTOR_ALLOCATOR_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define BSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication with the consequent in the same cycle
`define BSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent in the next cycle
`define BSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bsa_pkg.sv
package bsa_pkg;

  // default map size in bytes
  localparam int unsigned MapBytesDef = 128;

  // payload and register widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned SectorW = 10;
  localparam int unsigned CountW  = 16;
  localparam int unsigned BytesW  = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  // register reset values
  localparam logic [BytesW-1:0] BitmapBytesRst    = 8'd90;
  localparam logic [CountW-1:0] FormatCapacityRst = 16'd707;

  // byte patterns written by format, and the top-bit mask
  localparam logic [7:0] FirstByteFmt = 8'h0F;
  localparam logic [7:0] FreeByte     = 8'hFF;
  localparam logic [7:0] UsedByte     = 8'h00;
  localparam logic [7:0] TopBitMask   = 8'h80;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgBitmapBytes    = 1'b0,
    CfgFormatCapacity = 1'b1
  } cfg_idx_e;

  // request modes
  typedef enum logic [ModeW-1:0] {
    ModeFormat = 2'd0,
    ModeAlloc  = 2'd1,
    ModeMark   = 2'd2
  } mode_e;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StFmt,
    StScan,
    StMark,
    StResp
  } state_e;

  // position of the first set bit counted from bit 7
  function automatic logic [2:0] first_set(input logic [7:0] b);
    logic [2:0] idx;
    logic       found;
    idx   = 3'd0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && b[7-i]) begin
        idx   = 3'(i);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

### rtl/core/bsa_req_if.sv
interface bsa_req_if;
  logic                             valid;
  logic                             ready;
  logic [bsa_pkg::ModeW-1:0]        mode;
  logic [bsa_pkg::SectorW-1:0]      mark_sector;

  modport source (output valid, output mode, output mark_sector, input ready);
  modport sink   (input valid, input mode, input mark_sector, output ready);
endinterface

### rtl/core/bsa_rsp_if.sv
interface bsa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [bsa_pkg::SectorW-1:0]      sector;
  logic                             full_res;
  logic [bsa_pkg::CountW-1:0]       free_count;

  modport source (output valid, output sector, output full_res, output free_count,
                  input ready);
  modport sink   (input valid, input sector, input full_res, input free_count,
                  output ready);
endinterface

### rtl/core/bitmap_sector_allocator.sv
// channel   | dir | payload                          | handshake
// ----------+-----+----------------------------------+------------
// req_i     | in  | mode, mark_sector                | valid/ready
// rsp_o     | out | sector, full_res, free_count     | valid/ready
// cfg       | in  | cfg_idx_i, cfg_data_i            | cfg_we_i
//
// one request at a time, the map is read and written one byte per cycle
// format: writes all MAP_BYTES bytes; allocate: scans k bytes (1..n) for a free bit,
// none when no bytes are in use; mark: one byte, none beyond the map; unused mode: none
// after reset the map reads as all used until the first format sweeps it
// a waiting response holds the output register; the next request is still taken
// and only its final step waits for the output to drain
`include "bitmap_sector_allocator_macros.svh"

module bitmap_sector_allocator #(
  parameter int unsigned MAP_BYTES = bsa_pkg::MapBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bsa_pkg::CfgDataW-1:0]  cfg_data_i,
  bsa_req_if.sink                       req_i,
  bsa_rsp_if.source                     rsp_o
);

  localparam int unsigned AW = $clog2(MAP_BYTES);
  localparam int unsigned CW = $clog2(MAP_BYTES + 1);
  localparam logic [AW-1:0] LastAddr = AW'(MAP_BYTES - 1);

  // configuration registers
  logic [bsa_pkg::BytesW-1:0] bitmap_bytes_q;
  logic [bsa_pkg::CountW-1:0] fmt_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitmap_bytes_q <= bsa_pkg::BitmapBytesRst;
      fmt_cap_q      <= bsa_pkg::FormatCapacityRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsa_pkg::CfgBitmapBytes:    bitmap_bytes_q <= cfg_data_i[bsa_pkg::BytesW-1:0];
        bsa_pkg::CfgFormatCapacity: fmt_cap_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bytes in use, saturated to the map size
  logic [CW-1:0] n_used;
  assign n_used = (32'(bitmap_bytes_q) > 32'(MAP_BYTES)) ? CW'(MAP_BYTES)
                                                         : CW'(bitmap_bytes_q);

  // map memory
  logic [7:0]    mem [MAP_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // control and result registers
  bsa_pkg::state_e             state_q, state_d;
  logic [AW-1:0]               addr_q, addr_d;
  logic [2:0]                  bit_q, bit_d;
  logic                        init_q, init_d;
  logic [bsa_pkg::CountW-1:0]  counter_q, counter_d;
  logic [bsa_pkg::SectorW-1:0] sector_q, sector_d;
  logic                        full_q, full_d;
  logic                        out_valid_q, out_valid_d;
  logic [bsa_pkg::SectorW-1:0] out_sector_q, out_sector_d;
  logic                        out_full_q, out_full_d;
  logic [bsa_pkg::CountW-1:0]  out_count_q, out_count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsa_pkg::StIdle;
      init_q      <= 1'b0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    bit_q        <= bit_d;
    sector_q     <= sector_d;
    full_q       <= full_d;
    out_sector_q <= out_sector_d;
    out_full_q   <= out_full_d;
    out_count_q  <= out_count_d;
  end

  // map byte as seen by the logic: all used until the first format
  logic [7:0]    map_byte;
  logic [2:0]    hit_bit;
  logic [7:0]    mark_mask;
  logic [6:0]    mark_byte;
  logic          mark_in_map;
  logic [AW-1:0] mark_addr;

  assign map_byte    = init_q ? rdata_q : bsa_pkg::UsedByte;
  assign hit_bit     = bsa_pkg::first_set(map_byte);
  assign mark_mask   = bsa_pkg::TopBitMask >> bit_q;
  assign mark_byte   = req_i.mark_sector[bsa_pkg::SectorW-1:3];
  assign mark_in_map = 32'(mark_byte) < 32'(MAP_BYTES);
  assign mark_addr   = AW'(mark_byte);

  // sequencer
  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    bit_d        = bit_q;
    init_d       = init_q;
    counter_d    = counter_q;
    sector_d     = sector_q;
    full_d       = full_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_sector_d = out_sector_q;
    out_full_d   = out_full_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = bsa_pkg::UsedByte;
    rd_en        = 1'b0;
    rd_addr      = addr_q;
    req_i.ready  = 1'b0;

    unique case (state_q)
      bsa_pkg::StIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          sector_d = '0;
          full_d   = 1'b0;
          addr_d   = '0;
          unique case (req_i.mode)
            bsa_pkg::ModeFormat: state_d = bsa_pkg::StFmt;
            bsa_pkg::ModeAlloc: begin
              if (n_used == '0) begin
                full_d  = 1'b1;
                state_d = bsa_pkg::StResp;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = bsa_pkg::StScan;
              end
            end
            bsa_pkg::ModeMark: begin
              if (mark_in_map) begin
                rd_en   = 1'b1;
                rd_addr = mark_addr;
                addr_d  = mark_addr;
                bit_d   = req_i.mark_sector[2:0];
                state_d = bsa_pkg::StMark;
              end else begin
                state_d = bsa_pkg::StResp;
              end
            end
            default: state_d = bsa_pkg::StResp;
          endcase
        end
      end

      // one byte written per cycle over the whole map
      bsa_pkg::StFmt: begin
        mem_we = 1'b1;
        priority if (addr_q == '0) begin
          mem_wdata = bsa_pkg::FirstByteFmt;
        end else if (CW'(addr_q) < n_used) begin
          mem_wdata = bsa_pkg::FreeByte;
        end else begin
          mem_wdata = bsa_pkg::UsedByte;
        end
        if (addr_q == LastAddr) begin
          init_d    = 1'b1;
          counter_d = fmt_cap_q;
          state_d   = bsa_pkg::StResp;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end

      // first-fit scan, next byte read while this one is checked
      bsa_pkg::StScan: begin
        priority if (map_byte != bsa_pkg::UsedByte) begin
          mem_we    = 1'b1;
          mem_wdata = map_byte & ~(bsa_pkg::TopBitMask >> hit_bit);
          counter_d = counter_q - 16'd1;
          sector_d  = bsa_pkg::SectorW'({addr_q, hit_bit});
          state_d   = bsa_pkg::StResp;
        end else if (CW'(addr_q) + CW'(1) == n_used) begin
          full_d  = 1'b1;
          state_d = bsa_pkg::StResp;
        end else begin
          addr_d  = addr_q + AW'(1);
          rd_en   = 1'b1;
          rd_addr = addr_q + AW'(1);
        end
      end

      // clear one bit, count it only if it was free
      bsa_pkg::StMark: begin
        if ((map_byte & mark_mask) != bsa_pkg::UsedByte) begin
          mem_we    = 1'b1;
          mem_wdata = map_byte & ~mark_mask;
          counter_d = counter_q - 16'd1;
        end
        state_d = bsa_pkg::StResp;
      end

      // hand the response to the output register once it is free
      bsa_pkg::StResp: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_sector_d = sector_q;
          out_full_d   = full_q;
          out_count_d  = counter_q;
          state_d      = bsa_pkg::StIdle;
        end
      end

      default: state_d = bsa_pkg::StIdle;
    endcase
  end

  // response port
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.sector     = out_sector_q;
  assign rsp_o.full_res   = out_full_q;
  assign rsp_o.free_count = out_count_q;

  // checks
  `BSA_ASSERT_IMP(a_no_rw_same_addr, mem_we && rd_en, mem_waddr != rd_addr, "map read and write collide")
  `BSA_ASSERT_IMP(a_rsp_from_resp, $rose(out_valid_q), $past(state_q == bsa_pkg::StResp), "response loaded outside response step")
  `BSA_ASSERT_NXT(a_counter_hold, state_q == bsa_pkg::StIdle || state_q == bsa_pkg::StResp, $stable(counter_q), "free counter moved while idle")
  `BSA_ASSERT_IMP(a_write_needs_init, mem_we && state_q != bsa_pkg::StFmt, init_q, "map written before first format")

endmodule
